FILE: design/sed_pkg.sv
// Package for the string escape decoder.
// Holds the mode enum, error codes, character constants and result types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sed_pkg;

    // decoder mode, unused codes behave as plain text
    typedef enum logic [2:0] {
        MODE_PLAIN = 3'd0,
        MODE_ESC   = 3'd1,
        MODE_CR    = 3'd2,
        MODE_OCT1  = 3'd3,
        MODE_OCT2  = 3'd4,
        MODE_HEX0  = 3'd5,
        MODE_HEX1  = 3'd6
    } mode_t;

    // error codes
    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_OCTBIG  = 3'd1;
    localparam logic [2:0] ERR_BADHEX  = 3'd2;
    localparam logic [2:0] ERR_UNKESC  = 3'd3;
    localparam logic [2:0] ERR_NOQUOTE = 3'd4;
    localparam logic [2:0] ERR_NULL    = 3'd5;

    // source characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_LC_N  = 8'h6E;
    localparam logic [7:0] CH_LC_T  = 8'h74;
    localparam logic [7:0] CH_LC_V  = 8'h76;
    localparam logic [7:0] CH_LC_X  = 8'h78;

    localparam logic [8:0] BYTE_MAX = 9'd255;

    // one result item
    typedef struct packed {
        logic       string_done;
        logic [2:0] error_code;
        logic [7:0] out_byte;
        logic       has_byte;
    } res_t;

    // all results of one input item, second valid when two is set
    typedef struct packed {
        logic two;
        res_t r1;
        res_t r0;
    } entry_t;

endpackage

`default_nettype wire

FILE: design/sed_decode.sv
// Escape decoding step: mode and accumulator registers plus next-state logic.
// Depends on sed_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sed_decode (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           fire,
    input  wire logic [7:0]     in_byte,
    input  wire logic           at_end,
    output sed_pkg::entry_t     entry,
    output logic                emit
);
    import sed_pkg::*;

    typedef struct packed {
        logic  emit;
        res_t  res;
        mode_t mode;
    } plain_t;

    mode_t      mode_reg, mode_next;
    logic [8:0] accum_reg, accum_next;
    logic       end_flag;
    logic [4:0] hex_d;
    logic [8:0] oct_v;
    logic [7:0] pend_byte;
    plain_t     pl;

    function automatic res_t mk_res(input logic has, input logic [7:0] b,
                                    input logic [2:0] err, input logic done);
        res_t r;
        r.has_byte    = has;
        r.out_byte    = has ? b : 8'd0;
        r.error_code  = err;
        r.string_done = done;
        return r;
    endfunction

    // hex digit value, bit 4 marks a valid digit
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] v;
        v = 5'd0;
        if (b inside {[8'h30:8'h39]})
            v = {1'b1, b[3:0]};
        else if (b inside {[8'h61:8'h66]} || b inside {[8'h41:8'h46]})
            v = {1'b1, b[3:0] + 4'd9};
        return v;
    endfunction

    // plain text handling of one byte
    function automatic plain_t plain_step(input logic [7:0] b, input logic e);
        plain_t p;
        p.mode = MODE_PLAIN;
        p.emit = 1'b1;
        p.res  = mk_res(1'b1, b, ERR_NONE, 1'b0);
        if (b == CH_BSL) begin
            p.mode = MODE_ESC;
            p.emit = 1'b0;
        end else if (b == CH_QUOTE)
            p.res = mk_res(1'b0, 8'd0, ERR_NONE, 1'b1);
        else if (b == CH_LF || b == CH_CR)
            p.res = mk_res(1'b0, 8'd0, ERR_NOQUOTE, 1'b1);
        else if (b == CH_NUL)
            p.res = mk_res(1'b0, 8'd0, e ? ERR_NOQUOTE : ERR_NULL, e);
        return p;
    endfunction

    assign end_flag  = at_end && (in_byte == CH_NUL);
    assign hex_d     = hex_val(in_byte);
    assign oct_v     = {accum_reg[5:0], in_byte[2:0]};
    assign pend_byte = accum_reg[7:0];
    assign pl        = plain_step(in_byte, end_flag);

    // next mode and results for the current byte
    always_comb
    begin
        mode_next  = mode_reg;
        accum_next = accum_reg;
        emit       = 1'b0;
        entry      = '0;
        case (mode_reg)
            MODE_ESC:
            begin
                mode_next = MODE_PLAIN;
                emit      = 1'b1;
                case (in_byte)
                    CH_LC_N:  entry.r0 = mk_res(1'b1, CH_LF, ERR_NONE, 1'b0);
                    CH_LC_T:  entry.r0 = mk_res(1'b1, CH_TAB, ERR_NONE, 1'b0);
                    CH_BSL:   entry.r0 = mk_res(1'b1, CH_BSL, ERR_NONE, 1'b0);
                    CH_QUOTE: entry.r0 = mk_res(1'b1, CH_QUOTE, ERR_NONE, 1'b0);
                    CH_LC_V:  entry.r0 = mk_res(1'b1, CH_VT, ERR_NONE, 1'b0);
                    CH_LC_F:  entry.r0 = mk_res(1'b1, CH_FF, ERR_NONE, 1'b0);
                    CH_LC_A:  entry.r0 = mk_res(1'b1, CH_BEL, ERR_NONE, 1'b0);
                    CH_LF:    emit = 1'b0;
                    CH_CR:
                    begin
                        emit      = 1'b0;
                        mode_next = MODE_CR;
                    end
                    CH_LC_X:
                    begin
                        emit      = 1'b0;
                        mode_next = MODE_HEX0;
                    end
                    default:
                    begin
                        if (in_byte inside {[8'h30:8'h37]}) begin
                            emit       = 1'b0;
                            accum_next = {6'd0, in_byte[2:0]};
                            mode_next  = MODE_OCT1;
                        end else if (end_flag)
                            entry.r0 = mk_res(1'b0, 8'd0, ERR_NOQUOTE, 1'b1);
                        else
                            entry.r0 = mk_res(1'b1, in_byte, ERR_UNKESC, 1'b0);
                    end
                endcase
            end
            MODE_CR:
            begin
                mode_next = MODE_PLAIN;
                if (in_byte != CH_LF) begin
                    mode_next = pl.mode;
                    emit      = pl.emit;
                    entry.r0  = pl.res;
                end
            end
            MODE_OCT1, MODE_OCT2:
            begin
                emit = 1'b1;
                if (in_byte inside {[8'h30:8'h37]}) begin
                    if (mode_reg == MODE_OCT1) begin
                        emit       = 1'b0;
                        accum_next = oct_v;
                        mode_next  = MODE_OCT2;
                    end else begin
                        accum_next = 9'd0;
                        mode_next  = MODE_PLAIN;
                        if (oct_v > BYTE_MAX)
                            entry.r0 = mk_res(1'b0, 8'd0, ERR_OCTBIG, 1'b0);
                        else
                            entry.r0 = mk_res(1'b1, oct_v[7:0], ERR_NONE, 1'b0);
                    end
                end else begin
                    // pending value first, then the ending byte as plain text
                    accum_next = 9'd0;
                    mode_next  = pl.mode;
                    entry.r0   = mk_res(1'b1, pend_byte, ERR_NONE, 1'b0);
                    entry.r1   = pl.res;
                    entry.two  = pl.emit;
                end
            end
            MODE_HEX0:
            begin
                if (hex_d[4]) begin
                    accum_next = {5'd0, hex_d[3:0]};
                    mode_next  = MODE_HEX1;
                end else begin
                    emit      = 1'b1;
                    mode_next = MODE_PLAIN;
                    if (end_flag)
                        entry.r0 = mk_res(1'b0, 8'd0, ERR_NOQUOTE, 1'b1);
                    else
                        entry.r0 = mk_res(1'b1, in_byte, ERR_BADHEX, 1'b0);
                end
            end
            MODE_HEX1:
            begin
                emit       = 1'b1;
                accum_next = 9'd0;
                if (hex_d[4]) begin
                    mode_next = MODE_PLAIN;
                    entry.r0  = mk_res(1'b1, {accum_reg[3:0], hex_d[3:0]}, ERR_NONE, 1'b0);
                end else begin
                    mode_next = pl.mode;
                    entry.r0  = mk_res(1'b1, pend_byte, ERR_NONE, 1'b0);
                    entry.r1  = pl.res;
                    entry.two = pl.emit;
                end
            end
            default:
            begin
                mode_next = pl.mode;
                emit      = pl.emit;
                entry.r0  = pl.res;
            end
        endcase
    end

    // state registers advance on each consumed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= MODE_PLAIN;
            accum_reg <= 9'd0;
        end else if (fire) begin
            mode_reg  <= mode_next;
            accum_reg <= accum_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/sed_out_queue.sv
// Two-entry result queue; each entry holds the one or two results of a byte.
// Depends on sed_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sed_out_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_en,
    input  wire sed_pkg::entry_t wr_entry,
    output logic                 wr_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output sed_pkg::res_t        out_res,
    output logic                 out_last
);
    import sed_pkg::*;

    entry_t     entries_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg, sub_reg;
    logic [1:0] count_reg;
    entry_t     head;
    logic       pop;

    assign head      = entries_reg[rd_ptr_reg];
    assign wr_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_res   = sub_reg ? head.r1 : head.r0;
    assign out_last  = sub_reg || !head.two;
    assign pop       = out_valid && out_ready && out_last;

    // entry storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            entries_reg[wr_ptr_reg] <= wr_entry;
    end

    // pointers, count and result index within the head entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            sub_reg    <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
                sub_reg    <= 1'b0;
            end
            else if (out_valid && out_ready)
                sub_reg <= 1'b1;
            count_reg <= count_reg + {1'b0, wr_en} - {1'b0, pop};
        end
    end

endmodule

`default_nettype wire

FILE: design/string_escape_decoder.sv
// Top level of the string escape decoder: input register, decoder, result queue.
// Depends on sed_pkg, sed_decode and sed_out_queue.
`timescale 1ns / 1ps
`default_nettype none

// Decodes the bytes of a C-style string literal, one byte per transfer after the
// opening quote, into the string's bytes with error and end-of-literal flags.
// A byte is taken every clock cycle while the result queue has room; it is held in
// the input register, and its results in the result queue before they are offered.
// A byte gives zero results (a backslash, escape digits, line continuations) or one,
// but a byte that ends a pending octal or hex escape gives two, offered one after
// the other, so the sustained rate is then set by the single-result output port.
// The decoder returns to plain text after every result with string_done.

module string_escape_decoder (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  wire logic       s_axis_tuser,   // [0] at_end
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic [4:0]      m_axis_tuser,   // [0] has_byte, [3:1] error_code, [4] string_done
    output logic            m_axis_tlast
);
    import sed_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_end_reg;
    logic       consume;
    logic       q_ready;
    logic       dec_emit;
    entry_t     dec_entry;
    res_t       out_res;

    assign consume       = in_valid_reg && q_ready;
    assign s_axis_tready = !in_valid_reg || consume;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_end_reg  <= s_axis_tuser;
        end
    end

    // decode step
    sed_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (consume),
        .in_byte (in_byte_reg),
        .at_end  (in_end_reg),
        .entry   (dec_entry),
        .emit    (dec_emit)
    );

    // result queue toward the output port
    sed_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (consume && dec_emit),
        .wr_entry  (dec_entry),
        .wr_ready  (q_ready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = out_res.out_byte;
    assign m_axis_tuser = {out_res.string_done, out_res.error_code, out_res.has_byte};

endmodule

`default_nettype wire

FILE: design/sed_checker.sv
// Port-level checks for the string escape decoder, bound to the top level.
// Depends on string_escape_decoder.
`timescale 1ns / 1ps
`default_nettype none

module sed_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic [4:0] m_axis_tuser,
    input wire logic       m_axis_tlast
);

    // a stalled result transfer stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // the end of a literal carries no byte and closes the item
    a_done_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[4] |-> !m_axis_tuser[0] && m_axis_tlast)
        else $error("string end with a byte or not last");

    // no byte means zero data
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 8'd0)
        else $error("data without byte flag");

    // error code range, and octal overflow never carries a byte
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser[3:1] != 3'd6 && m_axis_tuser[3:1] != 3'd7 &&
            (m_axis_tuser[3:1] != 3'd1 || !m_axis_tuser[0]))
        else $error("bad error code");

endmodule

bind string_escape_decoder sed_checker u_sed_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
